// File: rtl/ewsd_pkg.sv
// Shared constants and control types of the error window settle detector.
package ewsd_pkg;

   localparam int FIELD_BITS            = 32;
   localparam int THRESH_BITS           = 31;
   localparam int WINDOW_DEFAULT        = 10;
   localparam int SAMPLE_BITS_DEFAULT   = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 31'd3277;
   localparam logic [THRESH_BITS-1:0] SQ_SAT          = '1;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TWO_CHANNELS = 1'b1;

   // Control of one window cell: shift takes the neighbor's value, or zero if zero is also set.
   typedef struct packed {
      logic shift;
      logic zero;
   } cell_ctrl_type;

   // Control of one channel scanner: first restarts the running min, max and test.
   typedef struct packed {
      logic en;
      logic first;
   } scan_ctrl_type;

endpackage

// File: rtl/ewsd_req_if.sv
// Input channel: one error sample word with restart flag.
interface ewsd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [ewsd_pkg::FIELD_BITS-1:0] err_first;
   logic signed [ewsd_pkg::FIELD_BITS-1:0] err_second;
   logic                                restart;

   modport source (output valid, output err_first, output err_second, output restart,
                   input ready);
   modport sink   (input valid, input err_first, input err_second, input restart,
                   output ready);
endinterface

// File: rtl/ewsd_rsp_if.sv
// Result channel: settle flags for one sample word.
interface ewsd_rsp_if;
   logic valid;
   logic ready;
   logic goal_reached;
   logic all_small;
   logic spread_small;

   modport source (output valid, output goal_reached, output all_small,
                   output spread_small, input ready);
   modport sink   (input valid, input goal_reached, input all_small,
                   input spread_small, output ready);
endinterface

// File: rtl/ewsd_cell.sv
// One window cell holding a sample of each channel.
module ewsd_cell #(
   parameter int SAMPLE_BITS = ewsd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ewsd_pkg::cell_ctrl_type       ctrl,
   input  logic signed [SAMPLE_BITS-1:0] din_first,
   input  logic signed [SAMPLE_BITS-1:0] din_second,
   output logic signed [SAMPLE_BITS-1:0] q_first,
   output logic signed [SAMPLE_BITS-1:0] q_second
);

   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic signed [SAMPLE_BITS-1:0] second_ff, second_in;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      if (ctrl.shift) begin
         first_in  = ctrl.zero ? '0 : din_first;
         second_in = ctrl.zero ? '0 : din_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign q_first  = first_ff;
   assign q_second = second_ff;

endmodule

// File: rtl/ewsd_scan.sv
// Running min, max and magnitude test over the samples of one channel.
module ewsd_scan #(
   parameter int SAMPLE_BITS = ewsd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  ewsd_pkg::scan_ctrl_type             ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       sample,
   input  logic [ewsd_pkg::THRESH_BITS-1:0]    threshold,
   output logic signed [SAMPLE_BITS-1:0]       lo,
   output logic signed [SAMPLE_BITS-1:0]       hi,
   output logic                                mag_ok
);

   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_BITS-1:0] hi_ff, hi_in;
   logic                          ok_ff, ok_in;
   logic [SAMPLE_BITS-1:0]        mag;
   logic                          mag_below;

   // The magnitude of the most negative value wraps to its own unsigned pattern.
   assign mag       = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   assign mag_below = 33'(mag) < 33'(threshold);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      ok_in = ok_ff;
      if (ctrl.en) begin
         if (ctrl.first) begin
            lo_in = sample;
            hi_in = sample;
            ok_in = mag_below;
         end else begin
            lo_in = (sample < lo_ff) ? sample : lo_ff;
            hi_in = (sample > hi_ff) ? sample : hi_ff;
            ok_in = ok_ff & mag_below;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ok_ff <= ok_in;
   end

   assign lo     = lo_ff;
   assign hi     = hi_ff;
   assign mag_ok = ok_ff;

endmodule

// File: rtl/error_window_settle_detector.sv
// Top level of the error window settle detector: cell chain, scanners and control.
//
// Each request word carries one error sample per channel. The samples enter a chain of
// WINDOW cells at its head; a word with restart set zeroes every other cell at the same
// time. The chain then rotates once around its full length, and two scanners, one per
// channel, watch the tail cell to collect the minimum, the maximum and the magnitude test.
// One shared 32 by 32 multiplier squares the spread of the first channel and then of the
// second, and the result word is loaded into the response register. A word is accepted,
// rotated past the scanners, and then squared and compared in the steps SQ1, SQ2 and SQ3.
// The next request
// word is taken as soon as the result is loaded, while that result may still wait on the
// response side; it is held back only when a second result is ready before the first has
// been taken. After reset the window holds zeros, and those zeros count as samples.
// Configuration writes (threshold, two-channel mode) must be made while no word is in work.
module error_window_settle_detector #(
   parameter int WINDOW        = ewsd_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS   = ewsd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = ewsd_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ewsd_req_if.sink                              req_if,
   ewsd_rsp_if.source                            rsp_if,
   input  logic                                  csr_we,
   input  logic [ewsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ewsd_pkg::THRESH_BITS-1:0]      csr_data
);

   localparam int CNT_BITS  = $clog2(WINDOW);
   localparam int PROD_BITS = 2 * SAMPLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SQ1,
      ST_SQ2,
      ST_SQ3
   } state_type;

   // Configuration registers.
   logic [ewsd_pkg::THRESH_BITS-1:0] threshold_ff;
   logic                             two_channels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= ewsd_pkg::THRESHOLD_RESET;
         two_channels_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            ewsd_pkg::CSR_THRESHOLD:    threshold_ff    <= csr_data;
            ewsd_pkg::CSR_TWO_CHANNELS: two_channels_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;
   logic                    spr1_ff, spr1_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    goal_ff, goal_in;
   logic                    all_ff, all_in;
   logic                    spread_ff, spread_in;

   logic accept;
   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   // Cell chain. The head takes the new word on accept and the tail while rotating.
   logic signed [SAMPLE_BITS-1:0] cell_first  [WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_second [WINDOW];
   logic signed [SAMPLE_BITS-1:0] head_first, head_second;
   ewsd_pkg::cell_ctrl_type       head_ctrl, body_ctrl;

   assign head_first  = accept ? req_if.err_first[SAMPLE_BITS-1:0]  : cell_first[WINDOW-1];
   assign head_second = accept ? req_if.err_second[SAMPLE_BITS-1:0] : cell_second[WINDOW-1];

   always_comb begin
      head_ctrl.shift = accept || (state_ff == ST_SCAN);
      head_ctrl.zero  = 1'b0;
      body_ctrl.shift = head_ctrl.shift;
      body_ctrl.zero  = accept && req_if.restart;
   end

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      if (i == 0) begin : g_head
         ewsd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (head_ctrl),
            .din_first  (head_first),
            .din_second (head_second),
            .q_first    (cell_first[i]),
            .q_second   (cell_second[i])
         );
      end else begin : g_body
         ewsd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (body_ctrl),
            .din_first  (cell_first[i-1]),
            .din_second (cell_second[i-1]),
            .q_first    (cell_first[i]),
            .q_second   (cell_second[i])
         );
      end
   end

   // Scanners watch the tail cell during the rotation.
   ewsd_pkg::scan_ctrl_type       scan_ctrl;
   logic signed [SAMPLE_BITS-1:0] lo1, hi1, lo2, hi2;
   logic                          ok1, ok2;

   always_comb begin
      scan_ctrl.en    = (state_ff == ST_SCAN);
      scan_ctrl.first = (cnt_ff == '0);
   end

   ewsd_scan #(.SAMPLE_BITS(SAMPLE_BITS)) u_scan_first (
      .clock     (clock),
      .ctrl      (scan_ctrl),
      .sample    (cell_first[WINDOW-1]),
      .threshold (threshold_ff),
      .lo        (lo1),
      .hi        (hi1),
      .mag_ok    (ok1)
   );

   ewsd_scan #(.SAMPLE_BITS(SAMPLE_BITS)) u_scan_second (
      .clock     (clock),
      .ctrl      (scan_ctrl),
      .sample    (cell_second[WINDOW-1]),
      .threshold (threshold_ff),
      .lo        (lo2),
      .hi        (hi2),
      .mag_ok    (ok2)
   );

   // Spread of the channel being squared; max minus min always fits unsigned.
   logic [SAMPLE_BITS:0]   diff1, diff2;
   logic [SAMPLE_BITS-1:0] spread_sel;
   assign diff1 = {hi1[SAMPLE_BITS-1], hi1} - {lo1[SAMPLE_BITS-1], lo1};
   assign diff2 = {hi2[SAMPLE_BITS-1], hi2} - {lo2[SAMPLE_BITS-1], lo2};
   assign spread_sel = (state_ff == ST_SQ1) ? diff1[SAMPLE_BITS-1:0] : diff2[SAMPLE_BITS-1:0];

   // Scaled and saturated square of the registered product, compared with the threshold.
   logic [PROD_BITS-1:0]             sq_shift;
   logic [ewsd_pkg::THRESH_BITS-1:0] sq_val;
   logic                             spr_now;
   assign sq_shift = prod_ff >> FRACTION_BITS;
   assign sq_val   = (sq_shift > PROD_BITS'(ewsd_pkg::SQ_SAT)) ?
                     ewsd_pkg::SQ_SAT : sq_shift[ewsd_pkg::THRESH_BITS-1:0];
   assign spr_now  = sq_val < threshold_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      spr1_in      = spr1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      goal_in      = goal_ff;
      all_in       = all_ff;
      spread_in    = spread_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(WINDOW - 1)) begin
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            prod_in  = PROD_BITS'(spread_sel) * PROD_BITS'(spread_sel);
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            spr1_in  = spr_now;
            prod_in  = PROD_BITS'(spread_sel) * PROD_BITS'(spread_sel);
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            // The second channel only counts in two-channel mode.
            if (!rsp_valid_ff || rsp_if.ready) begin
               all_in       = ok1 && (ok2 || !two_channels_ff);
               spread_in    = spr1_ff && (spr_now || !two_channels_ff);
               goal_in      = all_in && spread_in;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prod_ff   <= prod_in;
      spr1_ff   <= spr1_in;
      goal_ff   <= goal_in;
      all_ff    <= all_in;
      spread_ff <= spread_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.goal_reached = goal_ff;
   assign rsp_if.all_small    = all_ff;
   assign rsp_if.spread_small = spread_ff;

   // An accepted word always starts the rotation.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN)
      else $error("accepted word did not start the scan");

   // The rotation counter never passes the last cell.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= CNT_BITS'(WINDOW - 1))
      else $error("scan counter out of range");

   // A new result appears only at the end of the squaring steps.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SQ3))
      else $error("result raised outside the final step");

endmodule

// File: test/ewsd_settle_checker.sv
`timescale 1ns / 100ps
// Checker of the settle detector: watches both channels, predicts the settle flags and compares.
module ewsd_settle_checker (
   input  logic                                clock,
   input  logic                                reset,
   ewsd_req_if                                 req_mon,
   ewsd_rsp_if                                 rsp_mon,
   input  logic                                csr_we,
   input  logic [ewsd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ewsd_pkg::THRESH_BITS-1:0]    csr_data,
   output int                                  mismatch_count,
   output int                                  words_pending
);

   localparam int DEPTH = ewsd_pkg::WINDOW_DEFAULT;
   localparam int FRAC  = ewsd_pkg::FRACTION_BITS_DEFAULT;

   typedef struct packed {
      logic goal_reached;
      logic all_small;
      logic spread_small;
   } settle_flags_type;

   settle_flags_type                       expected_flags[$];
   logic signed [ewsd_pkg::FIELD_BITS-1:0] hist_first[DEPTH];
   logic signed [ewsd_pkg::FIELD_BITS-1:0] hist_second[DEPTH];
   int unsigned                            slot;
   logic [ewsd_pkg::THRESH_BITS-1:0]       limit;
   logic                                   dual;
   int                                     fails = 0;
   int                                     pending = 0;

   assign mismatch_count = fails;
   assign words_pending  = pending;

   // Magnitude test and squared spread test over one channel's history.
   function automatic void scan_channel(input bit use_second, output bit mag_ok,
                                        output bit spread_ok);
      longint          value;
      longint          lo;
      longint          hi;
      longint unsigned span;
      longint unsigned square;
      int              i;
      mag_ok = 1'b1;
      lo = use_second ? hist_second[0] : hist_first[0];
      hi = lo;
      for (i = 0; i < DEPTH; i++) begin
         value = use_second ? hist_second[i] : hist_first[i];
         if ((value < 0 ? -value : value) >= longint'(limit))
            mag_ok = 1'b0;
         if (value < lo)
            lo = value;
         if (value > hi)
            hi = value;
      end
      span = hi - lo;
      square = (span * span) >> FRAC;
      if (square > 64'(ewsd_pkg::SQ_SAT))
         square = 64'(ewsd_pkg::SQ_SAT);
      spread_ok = square < 64'(limit);
   endfunction

   function automatic settle_flags_type predict_settle(
      input logic signed [ewsd_pkg::FIELD_BITS-1:0] first,
      input logic signed [ewsd_pkg::FIELD_BITS-1:0] second,
      input logic restart);
      settle_flags_type flags;
      bit               mag_a;
      bit               spr_a;
      bit               mag_b;
      bit               spr_b;
      int               i;
      if (restart) begin
         for (i = 0; i < DEPTH; i++) begin
            hist_first[i]  = '0;
            hist_second[i] = '0;
         end
         slot = 0;
      end
      hist_first[slot]  = first;
      hist_second[slot] = second;
      slot = (slot + 1) % DEPTH;
      scan_channel(1'b0, mag_a, spr_a);
      mag_b = 1'b1;
      spr_b = 1'b1;
      if (dual)
         scan_channel(1'b1, mag_b, spr_b);
      flags.all_small    = mag_a && mag_b;
      flags.spread_small = spr_a && spr_b;
      flags.goal_reached = flags.all_small && flags.spread_small;
      return flags;
   endfunction

   function automatic void check_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, actual %0b", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      settle_flags_type want;
      int               i;
      if (reset) begin
         expected_flags.delete();
         for (i = 0; i < DEPTH; i++) begin
            hist_first[i]  = '0;
            hist_second[i] = '0;
         end
         slot  = 0;
         limit = ewsd_pkg::THRESHOLD_RESET;
         dual  = 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ewsd_pkg::CSR_THRESHOLD:    limit = csr_data;
               ewsd_pkg::CSR_TWO_CHANNELS: dual  = csr_data[0];
               default: ;
            endcase
         end
         // The result word leaving now belongs to an older request, so it is matched first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_flags.size() == 0) begin
               $error("settle word arrived with no request outstanding");
               fails++;
            end else begin
               want = expected_flags.pop_front();
               check_flag("goal_reached", want.goal_reached, rsp_mon.goal_reached);
               check_flag("all_small", want.all_small, rsp_mon.all_small);
               check_flag("spread_small", want.spread_small, rsp_mon.spread_small);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_flags.push_back(predict_settle(req_mon.err_first, req_mon.err_second,
                                                    req_mon.restart));
      end
      pending = expected_flags.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Top of the settle detector testbench: clock, reset, stimulus, response pacing and verdict.
module tb;

   // LATENCY is the time one word spends inside the block, and the drain pause is built from it.
   localparam int LATENCY         = ewsd_pkg::WINDOW_DEFAULT + 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 145;

   localparam logic signed [ewsd_pkg::FIELD_BITS-1:0] MOST_NEG =
      {1'b1, {(ewsd_pkg::FIELD_BITS-1){1'b0}}};
   localparam logic signed [ewsd_pkg::FIELD_BITS-1:0] MOST_POS =
      {1'b0, {(ewsd_pkg::FIELD_BITS-1){1'b1}}};
   localparam logic [ewsd_pkg::THRESH_BITS-1:0]       THRESH_MAX = '1;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [ewsd_pkg::CSR_INDEX_BITS-1:0] csr_index = ewsd_pkg::CSR_THRESHOLD;
   logic [ewsd_pkg::THRESH_BITS-1:0]    csr_data = '0;
   int                                  mismatches;
   int                                  pending;

   // Random gaps on both sides are on while idling is set. A set hold_request asks the
   // response side for one long stall; the response process clears it when it starts.
   bit     idling = 1'b1;
   bit     hold_request = 1'b0;
   // The threshold in force, kept only to scale the error sequences to it.
   longint cur_limit = ewsd_pkg::THRESHOLD_RESET;

   ewsd_req_if req_bus();
   ewsd_rsp_if rsp_bus();

   error_window_settle_detector DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ewsd_settle_checker settle_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatches),
      .words_pending  (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog: far beyond the slowest correct run, which stays well under a millisecond.
   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Offers one request word from a falling edge and returns at the falling edge after the
   // rising edge that took it. Valid stays high unless an idle burst comes first, so the
   // next word can follow back to back.
   task automatic send_word(input logic signed [ewsd_pkg::FIELD_BITS-1:0] first,
                            input logic signed [ewsd_pkg::FIELD_BITS-1:0] second,
                            input logic restart);
      int gap;
      gap = 0;
      if (idling && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.err_first  <= first;
      req_bus.err_second <= second;
      req_bus.restart    <= restart;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // A register write raises the write enable and then lowers it; the pause after it keeps two writes
   // from lowering and raising the write enable at the same edge.
   task automatic write_reg(input logic [ewsd_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [ewsd_pkg::THRESH_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (index == ewsd_pkg::CSR_THRESHOLD)
         cur_limit = value;
   endtask

   // Only bit zero selects the mode; the upper data bits are random and must not matter.
   task automatic set_channels(input logic dual);
      logic [ewsd_pkg::THRESH_BITS-1:0] value;
      value = ewsd_pkg::THRESH_BITS'($urandom());
      value[0] = dual;
      write_reg(ewsd_pkg::CSR_TWO_CHANNELS, value);
   endtask

   // Stops offering words and waits until every predicted word has come back, then lets
   // the block sit for a while so that it is surely idle before a register write.
   task automatic settle_down();
      req_bus.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (2 * LATENCY) @(negedge clock);
   endtask

   function automatic logic signed [ewsd_pkg::FIELD_BITS-1:0] clamp_sample(input longint v);
      if (v > MOST_POS)
         return MOST_POS;
      if (v < MOST_NEG)
         return MOST_NEG;
      return v[ewsd_pkg::FIELD_BITS-1:0];
   endfunction

   // Uniform value in the range from -span to +span.
   function automatic longint jitter(input longint span);
      longint r;
      r = {32'd0, $urandom()};
      return r % (2 * span + 1) - span;
   endfunction

   function automatic logic signed [ewsd_pkg::FIELD_BITS-1:0] raw_sample();
      case ($urandom_range(0, 5))
         0:       return MOST_NEG;
         1:       return MOST_POS;
         2:       return '0;
         default: return $urandom();
      endcase
   endfunction

   // One move as a controller sees it: a restart, then errors on both channels that halve
   // each tick from a large start and carry noise around half the threshold, with an
   // occasional spike. Long moves settle, short ones are cut off before they do.
   task automatic run_move(output int count);
      longint scale;
      longint amp_a;
      longint amp_b;
      longint noise;
      int     length;
      int     k;
      scale = (cur_limit > 0) ? cur_limit : 1;
      length = $urandom_range(4, 30);
      amp_a = scale * $urandom_range(0, 40);
      amp_b = scale * $urandom_range(0, 40);
      if ($urandom_range(0, 1))
         amp_a = -amp_a;
      if ($urandom_range(0, 1))
         amp_b = -amp_b;
      for (k = 0; k < length; k++) begin
         noise = ($urandom_range(0, 15) == 0) ? scale * 2 : scale / 2;
         if (noise > 2**30)
            noise = 2**30;
         // Now and then a move continues the previous window instead of restarting it.
         send_word(clamp_sample(amp_a + jitter(noise)), clamp_sample(amp_b + jitter(noise)),
                   k == 0 && $urandom_range(0, 9) != 0);
         amp_a = amp_a / 2;
         amp_b = amp_b / 2;
      end
      count = length;
   endtask

   // A short burst of unrelated words over the full range, restarts at random.
   task automatic run_noise(output int count);
      int k;
      count = $urandom_range(1, 4);
      for (k = 0; k < count; k++)
         send_word(raw_sample(), raw_sample(), $urandom_range(0, 7) == 0);
   endtask

   // The response side takes words with short random stalls, and once with a long one
   // that backs the block up until it refuses new request words.
   initial begin : response_pacing
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(1, 3);
            repeat (stall) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int                               sent;
      int                               chunk;
      int                               p;
      logic [ewsd_pkg::THRESH_BITS-1:0] level;
      req_bus.valid      = 1'b0;
      req_bus.err_first  = '0;
      req_bus.err_second = '0;
      req_bus.restart    = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset setting. The first word finds a window of zeros, and
      // those zeros count as samples, so it settles at once.
      send_word('0, '0, 1'b0);
      send_word(32'sd3276, -32'sd3276, 1'b0);
      // A magnitude equal to the threshold is not below it.
      send_word(32'sd3277, '0, 1'b0);
      send_word('0, -32'sd3277, 1'b1);
      // Extremes of both channels; the spread then saturates when squared.
      send_word(MOST_POS, MOST_NEG, 1'b1);
      send_word(MOST_NEG, MOST_POS, 1'b0);
      send_word(-32'sd1, 32'sd1, 1'b1);

      // One-channel mode: the second channel is stored but takes no part in the tests.
      settle_down();
      set_channels(1'b0);
      send_word('0, MOST_NEG, 1'b1);
      send_word(32'sd100, MOST_POS, 1'b0);

      // With a zero threshold nothing is below it, so every flag is low.
      settle_down();
      write_reg(ewsd_pkg::CSR_THRESHOLD, '0);
      send_word('0, '0, 1'b1);
      send_word(MOST_NEG, '0, 1'b0);

      // At 1.0 the magnitudes pass while the spread of 80000 fails once squared.
      settle_down();
      write_reg(ewsd_pkg::CSR_THRESHOLD, 31'd65536);
      set_channels(1'b1);
      send_word(32'sd40000, '0, 1'b1);
      send_word(-32'sd40000, 32'sd65535, 1'b0);

      // The largest threshold: a saturated square equals it and so still fails.
      settle_down();
      write_reg(ewsd_pkg::CSR_THRESHOLD, THRESH_MAX);
      send_word(MOST_POS - 1, '0, 1'b1);
      send_word(MOST_NEG + 1, '0, 1'b0);
      send_word('0, '0, 1'b1);
      send_word(32'sd1, -32'sd1, 1'b0);

      // Random phases, each under its own setting and each started from an idle block.
      for (p = 0; p < PHASES; p++) begin
         settle_down();
         case (p)
            0:       level = ewsd_pkg::THRESHOLD_RESET;
            1:       level = '0;
            2:       level = THRESH_MAX;
            3:       level = 31'd65536;
            4:       level = 31'd1;
            5:       level = ewsd_pkg::THRESH_BITS'($urandom_range(2, 200000));
            6:       level = ewsd_pkg::THRESH_BITS'($urandom());
            default: level = ewsd_pkg::THRESHOLD_RESET;
         endcase
         write_reg(ewsd_pkg::CSR_THRESHOLD, level);
         set_channels((p % 3) != 1);
         // The last phase runs at full rate on both sides.
         if (p == PHASES - 1)
            idling = 1'b0;
         // One phase opens with a long response stall while words keep being offered.
         if (p == 3)
            hold_request = 1'b1;
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            if ($urandom_range(0, 9) < 8)
               run_move(chunk);
            else
               run_noise(chunk);
            sent += chunk;
         end
      end

      settle_down();
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
